// ===== rtl/dsp_pkg.sv =====
package dsp_pkg;

  // Field widths
  localparam int POS_W     = 32;
  localparam int GAIN_W    = 16;
  localparam int SCORE_W   = 17;
  localparam int CFG_IDX_W = 8;

  // 1.0 in Q1.15
  localparam logic [GAIN_W-1:0] ONE_Q15 = 16'd32768;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_MARGIN    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_OPENNESS    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PULL        = 8'd3;

  // Register values after reset: 0.5, 0.15, 0.4, 0.3
  localparam logic [GAIN_W-1:0] RST_CLEAR_THRESHOLD = 16'd16384;
  localparam logic [GAIN_W-1:0] RST_SCORE_MARGIN    = 16'd4915;
  localparam logic [GAIN_W-1:0] RST_MIN_OPENNESS    = 16'd13107;
  localparam logic [GAIN_W-1:0] RST_MIN_PULL        = 16'd9830;

  // Item kinds
  localparam logic CMD_SOURCE = 1'b0;
  localparam logic CMD_PORTAL = 1'b1;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef struct packed {
    logic [GAIN_W-1:0] clear_threshold;
    logic [GAIN_W-1:0] score_margin;
    logic [GAIN_W-1:0] min_openness;
    logic [GAIN_W-1:0] min_pull;
  } cfg_t;

  typedef struct packed {
    logic              cmd;
    pos_t [2:0]        pos;
    logic [GAIN_W-1:0] direct_t;
    logic [GAIN_W-1:0] openness;
    logic [GAIN_W-1:0] src_gain;
    logic [GAIN_W-1:0] listener_gain;
    logic              last;
  } item_t;

  // One finished query, handed from front to back
  typedef struct packed {
    pos_t [2:0]        src;
    pos_t [2:0]        dst;
    logic [GAIN_W-1:0] k;
    logic              pull;
  } job_t;

  // Saturate a Q1.15 gain at 1.0
  function automatic logic [GAIN_W-1:0] clamp_one(input logic [GAIN_W-1:0] v);
    clamp_one = (v > ONE_Q15) ? ONE_Q15 : v;
  endfunction

endpackage

// ===== rtl/diffraction_source_pull.sv =====
// Diffraction source pull.
// Input stream (s_*): a source item (tuser = 0) opens a query, portal items
// (tuser = 1) follow, tlast marks the final item of the query. Output stream
// (m_*) carries one apparent source position per query, given on tlast.
// Configuration: cfg_index selects clear_threshold (0), score_margin (1),
// min_openness (2) or min_pull (3); other indexes are dropped. Write only
// while the block is idle.
// Throughput: one input item per cycle while s_tready is high; s_tready
// drops while a last item waits for room in the queue. Each item is scored
// on input, held in the item register and folded into the query state from
// there. A pulled query runs through three coordinates, four steps each on
// one shared 17x17 multiplier; an unpulled query goes straight to output.
// The back end takes a new query only after the last one has been output.
// Finished queries wait in a QUEUE_DEPTH-entry queue. When m_tready is low,
// the output holds, the queue fills, and then s_tready drops on the next
// last item. Reset clears the query state and loads register defaults.
module diffraction_source_pull #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  // pos_x, pos_y, pos_z, direct_t, openness, src_gain, listener_gain
  input  logic [159:0]                    s_tdata,
  // cmd
  input  logic                            s_tuser,
  input  logic                            s_tlast,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // out_x, out_y, out_z
  output logic [95:0]                     m_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dsp_pkg::GAIN_W-1:0]      cfg_data
);

  dsp_pkg::cfg_t       cfg;
  dsp_pkg::item_t      in_item;
  dsp_pkg::job_t       f_job, q_job;
  logic                f_valid, f_ready, q_valid, q_ready;
  dsp_pkg::pos_t [2:0] out_pos;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clear_threshold <= dsp_pkg::RST_CLEAR_THRESHOLD;
      cfg.score_margin    <= dsp_pkg::RST_SCORE_MARGIN;
      cfg.min_openness    <= dsp_pkg::RST_MIN_OPENNESS;
      cfg.min_pull        <= dsp_pkg::RST_MIN_PULL;
    end else if (cfg_valid) begin
      case (cfg_index)
        dsp_pkg::REG_CLEAR_THRESHOLD: cfg.clear_threshold <= cfg_data;
        dsp_pkg::REG_SCORE_MARGIN:    cfg.score_margin    <= cfg_data;
        dsp_pkg::REG_MIN_OPENNESS:    cfg.min_openness    <= cfg_data;
        dsp_pkg::REG_MIN_PULL:        cfg.min_pull        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpack the input transfer
  always_comb begin
    in_item.cmd           = s_tuser;
    in_item.pos[0]        = s_tdata[31:0];
    in_item.pos[1]        = s_tdata[63:32];
    in_item.pos[2]        = s_tdata[95:64];
    in_item.direct_t      = s_tdata[111:96];
    in_item.openness      = s_tdata[127:112];
    in_item.src_gain      = s_tdata[143:128];
    in_item.listener_gain = s_tdata[159:144];
    in_item.last          = s_tlast;
  end

  dsp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  dsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_job)
  );

  dsp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pos   (out_pos)
  );

  assign m_tdata = out_pos;

endmodule

// ===== rtl/dsp_front.sv =====
module dsp_front (
  input  logic            clk,
  input  logic            rst,
  input  dsp_pkg::cfg_t   cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  dsp_pkg::item_t  in_item,
  output logic            job_valid,
  input  logic            job_ready,
  output dsp_pkg::job_t   job
);

  // Scoring on the incoming item: clamp, min of the legs, times openness
  logic [dsp_pkg::GAIN_W-1:0]   st, pl, op, leg;
  logic [2*dsp_pkg::GAIN_W-1:0] prod;
  logic [dsp_pkg::GAIN_W-1:0]   in_score;
  logic                         in_cand;

  always_comb begin
    st       = dsp_pkg::clamp_one(in_item.src_gain);
    pl       = dsp_pkg::clamp_one(in_item.listener_gain);
    op       = dsp_pkg::clamp_one(in_item.openness);
    leg      = (st < pl) ? st : pl;
    prod     = {{dsp_pkg::GAIN_W{1'b0}}, leg} * {{dsp_pkg::GAIN_W{1'b0}}, op};
    in_score = prod[30:15];
    in_cand  = (in_item.openness >= cfg.min_openness);
  end

  // Classified item register
  logic                         p_valid;
  logic                         p_cmd;
  dsp_pkg::pos_t [2:0]          p_pos;
  logic [dsp_pkg::GAIN_W-1:0]   p_direct;
  logic                         p_cand;
  logic [dsp_pkg::GAIN_W-1:0]   p_score;
  logic                         p_last;

  // Query state
  dsp_pkg::pos_t [2:0]          source_pos, source_pos_next;
  logic [dsp_pkg::GAIN_W-1:0]   direct_level, direct_level_next;
  logic [dsp_pkg::SCORE_W-1:0]  best_score, best_score_next;
  dsp_pkg::pos_t [2:0]          best_pos, best_pos_next;
  logic                         have_best, have_best_next;

  logic fire;
  assign fire     = p_valid & (~p_last | job_ready);
  assign in_ready = ~p_valid | fire;

  // State update for the item in the register
  always_comb begin
    source_pos_next   = source_pos;
    direct_level_next = direct_level;
    best_score_next   = best_score;
    best_pos_next     = best_pos;
    have_best_next    = have_best;
    if (p_cmd == dsp_pkg::CMD_SOURCE) begin
      source_pos_next   = p_pos;
      direct_level_next = p_direct;
      best_score_next   = {1'b0, p_direct} + {1'b0, cfg.score_margin};
      have_best_next    = 1'b0;
    end else if (p_cand && ({1'b0, p_score} > best_score)) begin
      best_score_next = {1'b0, p_score};
      best_pos_next   = p_pos;
      have_best_next  = 1'b1;
    end
  end

  // Job built from the updated state; k = clamp(1 - direct, min_pull, 1)
  logic [dsp_pkg::GAIN_W:0] v;
  always_comb begin
    v        = {1'b0, dsp_pkg::ONE_Q15} - {1'b0, direct_level_next};
    job.src  = source_pos_next;
    job.dst  = best_pos_next;
    job.k    = (v < {1'b0, cfg.min_pull}) ? cfg.min_pull : v[dsp_pkg::GAIN_W-1:0];
    job.pull = have_best_next & (direct_level_next < cfg.clear_threshold);
  end

  assign job_valid = p_valid & p_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid      <= 1'b0;
      source_pos   <= '0;
      direct_level <= '0;
      best_score   <= '0;
      best_pos     <= '0;
      have_best    <= 1'b0;
    end else begin
      if (fire) begin
        source_pos   <= source_pos_next;
        direct_level <= direct_level_next;
        best_score   <= best_score_next;
        best_pos     <= best_pos_next;
        have_best    <= have_best_next;
      end
      if (in_ready) begin
        p_valid <= in_valid;
      end
    end
  end

  // Payload of the item register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      p_cmd    <= in_item.cmd;
      p_pos    <= in_item.pos;
      p_direct <= dsp_pkg::clamp_one(in_item.direct_t);
      p_cand   <= in_cand;
      p_score  <= in_score;
      p_last   <= in_item.last;
    end
  end

endmodule

// ===== rtl/dsp_queue.sv =====
module dsp_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  dsp_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output dsp_pkg::job_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dsp_pkg::job_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/dsp_back.sv =====
module dsp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  output logic                job_ready,
  input  dsp_pkg::job_t       job,
  output logic                out_valid,
  input  logic                out_ready,
  output dsp_pkg::pos_t [2:0] out_pos
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIFF = 6'b000010,
    S_MLO  = 6'b000100,
    S_MHI  = 6'b001000,
    S_ACC  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  localparam logic signed [51:0] SAT_MAX = 52'sd2147483647;
  localparam logic signed [51:0] SAT_MIN = -52'sd2147483648;
  localparam logic signed [51:0] HALF    = 52'sd16384;

  state_t              state;
  dsp_pkg::job_t       job_r;
  logic [1:0]          idx;
  logic signed [32:0]  diff_r;
  logic signed [33:0]  p_lo, p_hi;
  dsp_pkg::pos_t [2:0] res;

  dsp_pkg::pos_t       src_sel, dst_sel;
  logic signed [16:0]  mul_a, mul_b;
  logic signed [33:0]  mul_p;
  logic signed [51:0]  acc_w, step_w, sum_w;
  dsp_pkg::pos_t       sat_w;

  assign job_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_pos   = res;

  assign src_sel = job_r.src[idx];
  assign dst_sel = job_r.dst[idx];

  // Shared 17x17 multiplier: low half of the difference, then the high half
  always_comb begin
    mul_a = (state == S_MLO) ? $signed({1'b0, diff_r[15:0]}) : $signed(diff_r[32:16]);
    mul_b = $signed({1'b0, job_r.k});
    mul_p = 34'(mul_a) * 34'(mul_b);
  end

  // Recombine, round to nearest (ties up), add to source, saturate
  always_comb begin
    acc_w  = ($signed({{18{p_hi[33]}}, p_hi}) <<< 16) + $signed({{18{p_lo[33]}}, p_lo}) + HALF;
    step_w = acc_w >>> 15;
    sum_w  = $signed({{20{src_sel[31]}}, src_sel}) + step_w;
    if (sum_w > SAT_MAX) begin
      sat_w = 32'sh7fffffff;
    end else if (sum_w < SAT_MIN) begin
      sat_w = 32'sh80000000;
    end else begin
      sat_w = sum_w[31:0];
    end
  end

  // Sequencer: three coordinates, four steps each
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= 2'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            idx   <= 2'd0;
            state <= job.pull ? S_DIFF : S_OUT;
          end
        end
        S_DIFF: state <= S_MLO;
        S_MLO:  state <= S_MHI;
        S_MHI:  state <= S_ACC;
        S_ACC: begin
          if (idx == 2'd2) begin
            state <= S_OUT;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_DIFF;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && job_valid) begin
      job_r <= job;
      res   <= job.src;
    end
    if (state == S_DIFF) begin
      diff_r <= $signed({dst_sel[31], dst_sel}) - $signed({src_sel[31], src_sel});
    end
    if (state == S_MLO) begin
      p_lo <= mul_p;
    end
    if (state == S_MHI) begin
      p_hi <= mul_p;
    end
    if (state == S_ACC) begin
      res[idx] <= sat_w;
    end
  end

endmodule
